// ----- sv/gbn_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the Go-Back-N sender.
package gbn_pkg;

	// Sizing
	localparam int MAX_WINDOW = 16;
	localparam int SEQ_BITS   = 16;
	localparam int BASE_W     = SEQ_BITS + 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int WIN_W      = 5;
	localparam int LIMIT_W    = 8;
	localparam int CFG_IDX_W  = 2;

	// Register reset values
	localparam logic [WIN_W-1:0]    WINDOW_RST  = WIN_W'(4);
	localparam logic [SEQ_BITS-1:0] TOTAL_RST   = SEQ_BITS'(10);
	localparam logic [LIMIT_W-1:0]  TIMEOUT_RST = LIMIT_W'(10);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

	// Event kinds
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ACK  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_RESP,
		ST_SEND
	} gbn_state_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;     // latch the incoming event
		logic load_upper;  // register the end of the send burst
		logic emit_resp;   // load the single result of an ack or idle tick
		logic emit_send;   // load one send order
	} gbn_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_ack;
		logic done;
		logic none_to_send;
		logic last_send;
		logic can_load;
	} gbn_status_t;

endpackage

// ----- sv/go_back_n_sender.sv -----
// Go-Back-N sender top level: controller, datapath and interface assertions.
//
// Use: each input transfer on the in_* channel is an event, op = 0 a tick, op = 1 an
// acknowledgement carrying ack_seq. Every event yields one or more result transfers on
// the out_* channel; the final one of an event carries last. A tick yields one send
// order per packet from the next sequence number to the end of the window (at most
// MAX_WINDOW), or a single no-send result when nothing is eligible.
// Timing: one event at a time. The first result is registered after capture, window
// evaluation and output load. A tick that sends packets gives one send order per cycle
// through the single output register while out_stall is low.
// Configuration: cfg_valid/cfg_ready writes window_size (0), packet_total (1) and
// timeout_limit (2); cfg_ready is always high; write only while no event is pending.
// Reset: base and next sequence number go to 1, the timeout count clears, registers
// return to 4 / 10 / 10 and the output register empties.
// Stall: while out_stall is high the pending result holds and the burst pauses; in_stall
// stays high until the current event has loaded its last result.
module go_back_n_sender (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gbn_pkg::SEQ_BITS-1:0]       cfg_data,
	// event channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               op,
	input  logic [gbn_pkg::SEQ_BITS-1:0]       ack_seq,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               send_valid,
	output logic [gbn_pkg::SEQ_BITS-1:0]       send_seq,
	output logic                               ack_accepted,
	output logic                               timed_out,
	output logic                               all_done,
	output logic                               last
);
	import gbn_pkg::*;

	gbn_cmd_t    cmd;
	gbn_status_t status;

	assign cfg_ready = 1'b1;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	gbn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op),
		.ack_seq      (ack_seq),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.send_valid   (send_valid),
		.send_seq     (send_seq),
		.ack_accepted (ack_accepted),
		.timed_out    (timed_out),
		.all_done     (all_done),
		.last         (last),
		.cmd          (cmd),
		.status       (status)
	);

	// No result is loaded while the controller is open for a new event
	a_idle_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !(cmd.emit_resp || cmd.emit_send))
		else $error("result loaded while idle");

	// A load never overwrites a result that is still stalled
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_resp || cmd.emit_send) |-> (!out_valid || !out_stall))
		else $error("output register overwritten");

	// A send order is never an ack result and never reports completion
	a_send_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && send_valid) |-> (!ack_accepted && !all_done))
		else $error("send order carries ack or done flag");

	// A timeout is only reported on the final result of a tick
	a_timeout_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && timed_out) |-> last)
		else $error("timeout flag on a non-final result");

endmodule

// ----- sv/gbn_ctrl.sv -----
// Controller state machine: sequences event capture, burst setup and result transfers.
module gbn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  gbn_pkg::gbn_status_t status,
	output gbn_pkg::gbn_cmd_t    cmd
);
	import gbn_pkg::*;

	gbn_state_t state_q;
	gbn_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				cmd.load_upper = 1'b1;
				if (status.is_ack || status.done || status.none_to_send) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_SEND;
				end
			end
			ST_RESP: begin
				cmd.emit_resp = status.can_load;
				if (status.can_load) begin
					state_d = ST_IDLE;
				end
			end
			ST_SEND: begin
				cmd.emit_send = status.can_load;
				if (status.can_load && status.last_send) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/gbn_dp.sv -----
// Datapath: configuration, window state, timeout counter and the output register.
module gbn_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// configuration writes
	input  logic                                      cfg_valid,
	input  logic [gbn_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [gbn_pkg::SEQ_BITS-1:0]              cfg_data,
	// event payload
	input  logic                                      op,
	input  logic [gbn_pkg::SEQ_BITS-1:0]              ack_seq,
	// result channel
	output logic                                      out_valid,
	input  logic                                      out_stall,
	output logic                                      send_valid,
	output logic [gbn_pkg::SEQ_BITS-1:0]              send_seq,
	output logic                                      ack_accepted,
	output logic                                      timed_out,
	output logic                                      all_done,
	output logic                                      last,
	// controller link
	input  gbn_pkg::gbn_cmd_t                         cmd,
	output gbn_pkg::gbn_status_t                      status
);
	import gbn_pkg::*;

	// Configuration
	logic [WIN_W-1:0]    window_q;
	logic [SEQ_BITS-1:0] total_q;
	logic [LIMIT_W-1:0]  limit_q;

	// Protocol state
	logic [BASE_W-1:0]   base_q;
	logic [BASE_W-1:0]   next_q;
	logic [LIMIT_W-1:0]  wait_q;

	// Event and burst bookkeeping
	logic                op_q;
	logic [SEQ_BITS-1:0] ack_q;
	logic [BASE_W-1:0]   upper_q;
	logic [CNT_W-1:0]    cnt_q;

	// Output register
	logic                out_valid_q;
	logic                send_valid_q;
	logic [SEQ_BITS-1:0] send_seq_q;
	logic                ack_acc_q;
	logic                timed_out_q;
	logic                all_done_q;
	logic                last_q;

	logic [BASE_W-1:0]   total_ext;
	logic [BASE_W-1:0]   win_eff;
	logic [BASE_W-1:0]   upper_raw;
	logic [BASE_W-1:0]   upper_d;
	logic [BASE_W-1:0]   base_inc;
	logic                done;
	logic                ack_match;
	logic                ack_ok;
	logic                expired;
	logic                last_send;
	logic                can_load;
	logic                tick_final;

	assign total_ext = {1'b0, total_q};
	assign done      = base_q > total_ext;
	assign base_inc  = base_q + BASE_W'(1);
	assign ack_match = {1'b0, ack_q} == base_q;
	assign ack_ok    = !done && ack_match;
	assign expired   = wait_q >= limit_q;
	assign can_load  = !out_valid_q || !out_stall;

	// Window saturated to 1 .. MAX_WINDOW, burst ends at min(base + w - 1, total)
	always_comb begin
		if (window_q == '0) begin
			win_eff = BASE_W'(1);
		end else if (BASE_W'(window_q) > BASE_W'(MAX_WINDOW)) begin
			win_eff = BASE_W'(MAX_WINDOW);
		end else begin
			win_eff = BASE_W'(window_q);
		end
		upper_raw = base_q + win_eff - BASE_W'(1);
		upper_d   = (upper_raw > total_ext) ? total_ext : upper_raw;
	end

	// Final send of a burst: reached the end or the burst length cap
	assign last_send = (next_q == upper_q) || (cnt_q == CNT_W'(MAX_WINDOW - 1));

	// The last result of a tick that is not yet done runs the timeout
	assign tick_final = (cmd.emit_resp && op_q == OP_TICK && !done) ||
		(cmd.emit_send && last_send);

	always_comb begin
		status              = '0;
		status.is_ack       = op_q == OP_ACK;
		status.done         = done;
		status.none_to_send = next_q > upper_d;
		status.last_send    = last_send;
		status.can_load     = can_load;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			total_q  <= TOTAL_RST;
			limit_q  <= TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WINDOW:  window_q <= cfg_data[WIN_W-1:0];
				CFG_TOTAL:   total_q  <= cfg_data;
				CFG_TIMEOUT: limit_q  <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Window base, next sequence number and timeout counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_W'(1);
			next_q <= BASE_W'(1);
			wait_q <= '0;
		end else begin
			if (cmd.emit_resp && op_q == OP_ACK && ack_ok) begin
				base_q <= base_inc;
				wait_q <= '0;
				if (next_q < base_inc) begin
					next_q <= base_inc;
				end
			end else if (tick_final) begin
				if (expired) begin
					next_q <= base_q;
					wait_q <= '0;
				end else begin
					wait_q <= wait_q + LIMIT_W'(1);
					if (cmd.emit_send) begin
						next_q <= next_q + BASE_W'(1);
					end
				end
			end else if (cmd.emit_send) begin
				next_q <= next_q + BASE_W'(1);
			end
		end
	end

	// Event capture and burst setup
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op;
			ack_q <= ack_seq;
		end
		if (cmd.load_upper) begin
			upper_q <= upper_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load_upper) begin
			cnt_q <= '0;
		end else if (cmd.emit_send) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_resp || cmd.emit_send) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (cmd.emit_send) begin
			send_valid_q <= 1'b1;
			send_seq_q   <= next_q[SEQ_BITS-1:0];
			ack_acc_q    <= 1'b0;
			timed_out_q  <= last_send && expired;
			all_done_q   <= 1'b0;
			last_q       <= last_send;
		end else if (cmd.emit_resp) begin
			send_valid_q <= 1'b0;
			send_seq_q   <= '0;
			last_q       <= 1'b1;
			if (op_q == OP_ACK) begin
				ack_acc_q   <= ack_ok;
				timed_out_q <= 1'b0;
				all_done_q  <= ack_ok ? (base_inc > total_ext) : done;
			end else begin
				ack_acc_q   <= 1'b0;
				timed_out_q <= !done && expired;
				all_done_q  <= done;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign send_valid   = send_valid_q;
	assign send_seq     = send_seq_q;
	assign ack_accepted = ack_acc_q;
	assign timed_out    = timed_out_q;
	assign all_done     = all_done_q;
	assign last         = last_q;

endmodule

// ----- dv/tb_go_back_n_sender.sv -----
// Self-checking testbench for the Go-Back-N sender: directed and random event traffic checked per result.
`timescale 1ns / 100ps

module tb_go_back_n_sender;
	import gbn_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic                op;
		logic [SEQ_BITS-1:0] ack_seq;
	} gbn_event_t;

	typedef struct packed {
		logic                send_valid;
		logic [SEQ_BITS-1:0] send_seq;
		logic                ack_accepted;
		logic                timed_out;
		logic                all_done;
		logic                last;
	} gbn_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
	logic [SEQ_BITS-1:0]  cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 op = OP_TICK;
	logic [SEQ_BITS-1:0]  ack_seq = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 send_valid;
	logic [SEQ_BITS-1:0]  send_seq;
	logic                 ack_accepted;
	logic                 timed_out;
	logic                 all_done;
	logic                 last;

	// Predicted sender state and register settings
	logic [BASE_W-1:0]   exp_base = BASE_W'(1);
	logic [BASE_W-1:0]   exp_next = BASE_W'(1);
	logic [LIMIT_W-1:0]  exp_wait = '0;
	logic [WIN_W-1:0]    win_setting = WINDOW_RST;
	logic [SEQ_BITS-1:0] total_setting = TOTAL_RST;
	logic [LIMIT_W-1:0]  limit_setting = TIMEOUT_RST;

	gbn_event_t  pending_events[$];
	gbn_result_t results_due[$];
	gbn_event_t  cur_event;
	int          events_in_flight = 0;
	int          error_count = 0;
	int          burst_left = 0;
	int          gap_left = 0;
	logic [15:0] stall_tick = '0;

	go_back_n_sender uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.ack_seq     (ack_seq),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.send_valid  (send_valid),
		.send_seq    (send_seq),
		.ack_accepted(ack_accepted),
		.timed_out   (timed_out),
		.all_done    (all_done),
		.last        (last)
	);

	always #10 clk = ~clk;

	// Work out the results of one accepted event and advance the predicted state
	task automatic predict_event(input gbn_event_t ev);
		logic              done_now;
		logic [BASE_W-1:0] win;
		logic [BASE_W-1:0] upper;
		logic              went_back;
		int                n;
		gbn_result_t       r;
		done_now = exp_base > BASE_W'(total_setting);
		r = '0;
		r.last = 1'b1;
		if (ev.op == OP_ACK) begin
			if (!done_now && BASE_W'(ev.ack_seq) == exp_base) begin
				exp_base = exp_base + 1'b1;
				exp_wait = '0;
				// ack that overtakes the send pointer drags it along
				if (exp_next < exp_base)
					exp_next = exp_base;
				r.ack_accepted = 1'b1;
			end
			r.all_done = exp_base > BASE_W'(total_setting);
			results_due.push_back(r);
		end else if (done_now) begin
			r.all_done = 1'b1;
			results_due.push_back(r);
		end else begin
			// window saturates to 1 .. MAX_WINDOW
			win = BASE_W'(win_setting);
			if (win == 0)
				win = BASE_W'(1);
			if (win > BASE_W'(MAX_WINDOW))
				win = BASE_W'(MAX_WINDOW);
			upper = exp_base + win - 1'b1;
			if (upper > BASE_W'(total_setting))
				upper = BASE_W'(total_setting);
			n = (exp_next <= upper) ? int'(upper - exp_next) + 1 : 0;
			if (n > MAX_WINDOW)
				n = MAX_WINDOW;
			went_back = exp_wait >= limit_setting;
			for (int k = 0; k < n; k++) begin
				r = '0;
				r.send_valid = 1'b1;
				r.send_seq = SEQ_BITS'(exp_next + BASE_W'(k));
				r.timed_out = went_back && (k == n - 1);
				r.last = (k == n - 1);
				results_due.push_back(r);
			end
			if (n == 0) begin
				r.timed_out = went_back;
				results_due.push_back(r);
			end
			exp_next = exp_next + BASE_W'(n);
			if (went_back) begin
				exp_next = exp_base;
				exp_wait = '0;
			end else begin
				exp_wait = exp_wait + 1'b1;
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	task automatic queue_event(input logic kind, input logic [SEQ_BITS-1:0] seq);
		gbn_event_t ev;
		ev.op = kind;
		ev.ack_seq = seq;
		pending_events.push_back(ev);
		events_in_flight++;
	endtask

	// Block is idle once every event is accepted and every result has come out
	task automatic wait_idle();
		do
			@(posedge clk);
		while (events_in_flight != 0 || results_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEQ_BITS-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WINDOW:  win_setting = data[WIN_W-1:0];
			CFG_TOTAL:   total_setting = data;
			CFG_TIMEOUT: limit_setting = data[LIMIT_W-1:0];
			default:     ;
		endcase
	endtask

	// Event driver: bursts of transfers separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_TICK;
			ack_seq <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_event(cur_event);
				events_in_flight--;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left != 0 || pending_events.size() == 0) begin
					if (gap_left != 0)
						gap_left--;
					in_valid <= 1'b0;
				end else begin
					cur_event = pending_events.pop_front();
					in_valid <= 1'b1;
					op <= cur_event.op;
					ack_seq <= cur_event.ack_seq;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 10);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
			end
		end
	end

	// Result monitor and receiver stall pattern
	always @(posedge clk or negedge arst_n) begin
		gbn_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					error_count++;
					$display("%0t: result with none expected, actual send_valid %0b send_seq %0h last %0b",
						$time, send_valid, send_seq, last);
				end else begin
					want = results_due.pop_front();
					check_field("send_valid", 32'(want.send_valid), 32'(send_valid));
					check_field("send_seq", 32'(want.send_seq), 32'(send_seq));
					check_field("ack_accepted", 32'(want.ack_accepted), 32'(ack_accepted));
					check_field("timed_out", 32'(want.timed_out), 32'(timed_out));
					check_field("all_done", 32'(want.all_done), 32'(all_done));
					check_field("last", 32'(want.last), 32'(last));
				end
			end
			stall_tick <= stall_tick + 1'b1;
			case (stall_tick[8:7])
				2'd0:    out_stall <= 1'b0;
				2'd1:    out_stall <= ($urandom_range(0, 9) < 4);
				2'd2:    out_stall <= (stall_tick[2:0] != 3'd0);
				default: out_stall <= stall_tick[0];
			endcase
		end
	end

	// Stimulus
	initial begin
		logic [BASE_W-1:0]   plan_base;
		logic [SEQ_BITS-1:0] plan_total;
		logic [SEQ_BITS-1:0] seq;
		logic [WIN_W-1:0]    win;
		logic [LIMIT_W-1:0]  lim;
		logic                kind;
		int                  n_events;
		int                  pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: ack overtaking the send pointer, full window, stray acks
		queue_event(OP_ACK, 16'd1);
		queue_event(OP_TICK, 16'hFFFF);
		queue_event(OP_TICK, 16'd0);
		queue_event(OP_ACK, 16'd3);
		queue_event(OP_ACK, 16'hFFFF);
		queue_event(OP_ACK, 16'd0);
		queue_event(OP_ACK, 16'd2);
		queue_event(OP_TICK, 16'd0);
		wait_idle();

		// Zero timeout: every tick goes back
		write_reg(CFG_TIMEOUT, 16'd0);
		queue_event(OP_TICK, 16'd0);
		queue_event(OP_TICK, 16'd0);
		wait_idle();

		// Window above range saturates
		write_reg(CFG_WINDOW, 16'd31);
		queue_event(OP_TICK, 16'd0);
		wait_idle();

		// Zero total: done from the start, acks ignored
		write_reg(CFG_TOTAL, 16'd0);
		queue_event(OP_TICK, 16'd0);
		queue_event(OP_ACK, 16'd3);
		wait_idle();

		// Largest total and limit, widest window: one full burst
		write_reg(CFG_TOTAL, 16'hFFFF);
		write_reg(CFG_WINDOW, 16'd16);
		write_reg(CFG_TIMEOUT, 16'd255);
		queue_event(OP_TICK, 16'd0);
		queue_event(OP_ACK, 16'd3);
		queue_event(OP_TICK, 16'd0);
		wait_idle();

		// Window of zero saturates to one
		write_reg(CFG_WINDOW, 16'd0);
		write_reg(CFG_TIMEOUT, 16'd1);
		queue_event(OP_TICK, 16'd0);
		queue_event(OP_TICK, 16'd0);
		queue_event(OP_TICK, 16'd0);

		// Random phases: mostly in-order acks and ticks, some noise
		for (int p = 0; p < 10; p++) begin
			wait_idle();
			plan_base = exp_base;
			case (p % 5)
				0:       win = 5'd0;
				1:       win = 5'd1;
				2:       win = 5'd16;
				3:       win = 5'd31;
				default: win = WIN_W'($urandom_range(2, 15));
			endcase
			case (p % 4)
				0:       lim = 8'd0;
				1:       lim = 8'd255;
				2:       lim = 8'd1;
				default: lim = LIMIT_W'($urandom_range(2, 12));
			endcase
			if (p == 3)
				plan_total = 16'hFFFF;
			else if (p == 7)
				plan_total = 16'd1;
			else
				plan_total = SEQ_BITS'(plan_base - 1'b1 + BASE_W'($urandom_range(3, 30)));
			write_reg(CFG_WINDOW, {11'($urandom), win});
			write_reg(CFG_TIMEOUT, {8'($urandom), lim});
			write_reg(CFG_TOTAL, plan_total);
			if (p == 5)
				write_reg(CFG_UNUSED, 16'($urandom));

			n_events = $urandom_range(15, 25);
			for (int i = 0; i < n_events; i++) begin
				pick = $urandom_range(0, 99);
				kind = OP_ACK;
				if (pick < 45) begin
					kind = OP_TICK;
					seq = 16'($urandom);
				end else if (pick < 85) begin
					seq = plan_base[SEQ_BITS-1:0];
				end else begin
					case ($urandom_range(0, 2))
						0:       seq = 16'($urandom);
						1:       seq = SEQ_BITS'(plan_base - 1'b1);
						default: seq = SEQ_BITS'(plan_base + BASE_W'($urandom_range(1, 3)));
					endcase
				end
				if (kind == OP_ACK && BASE_W'(seq) == plan_base
						&& plan_base <= BASE_W'(plan_total))
					plan_base = plan_base + 1'b1;
				queue_event(kind, seq);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (results_due.size() != 0) begin
			error_count++;
			$display("%0t: %0d results expected but never seen", $time, results_due.size());
		end
		if (error_count == 0)
			$display("tb_go_back_n_sender: done, clean");
		else
			$display("tb_go_back_n_sender: done, errors");
		$finish;
	end

	// Run limit
	initial begin
		#10_000_000;
		$display("tb_go_back_n_sender: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
sv/gbn_pkg.sv
sv/gbn_ctrl.sv
sv/gbn_dp.sv
sv/go_back_n_sender.sv
dv/tb_go_back_n_sender.sv
